// ===== design/ucdtg_pkg.sv =====
// Shared types and constants for the serial-commanded dual tone generator.
package ucdtg_pkg;

    localparam int BYTE_W = 8;
    localparam int FREQ_W = 16;
    localparam int CNT_W  = 16;

    localparam logic [BYTE_W-1:0] OPC_HELLO = 8'd0;
    localparam logic [BYTE_W-1:0] OPC_TONE  = 8'd1;

    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    // Where the byte parser stands inside a play command.
    typedef enum logic [1:0] {
        PH_CMD  = 2'd0,
        PH_SPK  = 2'd1,
        PH_LO   = 2'd2,
        PH_HI   = 2'd3
    } phase_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic take;    // apply the accepted item this cycle
        logic commit;  // write the finished quotient into the compare register
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic need_div;  // the presented item is a play that needs a divide
        logic div_done;  // the divider finished this cycle
    } status_t;

endpackage

// ===== design/ucdtg_req_if.sv =====
// Input channel: received serial bytes and timer ticks.
interface ucdtg_req_if import ucdtg_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              kind;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, output kind, output rx_byte, input ready);
    modport sink   (input valid, input kind, input rx_byte, output ready);
endinterface

// ===== design/ucdtg_rsp_if.sv =====
// Output channel: reply byte and speaker levels.
interface ucdtg_rsp_if import ucdtg_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              tx_valid;
    logic [BYTE_W-1:0] tx_byte;
    logic [1:0]        tone_levels;

    modport source (output valid, output tx_valid, output tx_byte, output tone_levels,
                    input ready);
    modport sink   (input valid, input tx_valid, input tx_byte, input tone_levels,
                    output ready);
endinterface

// ===== design/ucdtg_divider.sv =====
// Restoring divider of a fixed dividend by a 16-bit divisor, one quotient bit per cycle.
module ucdtg_divider import ucdtg_pkg::*; #(
    parameter int DIVIDEND = 500000
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic [FREQ_W-1:0]                   divisor,
    output logic                                done,
    output logic [$clog2(DIVIDEND+1)-1:0]       quotient
);

    localparam int DW = $clog2(DIVIDEND + 1);
    localparam int CW = $clog2(DW + 1);

    logic [FREQ_W-1:0] divisor_reg;
    logic [FREQ_W-1:0] rem_reg, rem_next;
    logic [DW-1:0]     quo_reg, quo_next;
    logic [CW-1:0]     step_cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [FREQ_W:0]   rem_shift;
    logic              fits;

    // The remainder stays below the divisor, so the shifted value fits in 17 bits.
    always_comb
    begin
        rem_shift = {rem_reg, quo_reg[DW-1]};
        fits      = rem_shift >= {1'b0, divisor_reg};
        rem_next  = fits ? FREQ_W'(rem_shift - {1'b0, divisor_reg}) : rem_shift[FREQ_W-1:0];
        quo_next  = {quo_reg[DW-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg     <= 1'b0;
            done_reg     <= 1'b0;
            step_cnt_reg <= '0;
            rem_reg      <= '0;
            quo_reg      <= '0;
            divisor_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg     <= 1'b1;
                step_cnt_reg <= CW'(DW);
                rem_reg      <= '0;
                quo_reg      <= DW'(DIVIDEND);
                divisor_reg  <= divisor;
            end
            else if (busy_reg)
            begin
                rem_reg      <= rem_next;
                quo_reg      <= quo_next;
                step_cnt_reg <= step_cnt_reg - CW'(1);
                if (step_cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== design/ucdtg_datapath.sv =====
// Datapath: command parser registers, speaker timers, divider and result register.
module ucdtg_datapath import ucdtg_pkg::*; #(
    parameter int NUM_SPEAKERS   = 2,
    parameter int TIMER_CLOCK_HZ = 500000
) (
    input  logic              clk,
    input  logic              rst_n,
    input  cmd_t              cmd,
    output status_t           status,
    input  logic              kind,
    input  logic [BYTE_W-1:0] rx_byte,
    output logic              tx_valid,
    output logic [BYTE_W-1:0] tx_byte,
    output logic [1:0]        tone_levels
);

    localparam int QW = $clog2(TIMER_CLOCK_HZ + 1);

    phase_t            phase_reg, phase_next;
    logic [BYTE_W-1:0] pending_speaker_reg, pending_speaker_next;
    logic [BYTE_W-1:0] pending_freq_low_reg, pending_freq_low_next;
    logic [CNT_W-1:0]  compare_value_reg [NUM_SPEAKERS];
    logic [CNT_W-1:0]  compare_value_next [NUM_SPEAKERS];
    logic [CNT_W-1:0]  tick_counter_reg [NUM_SPEAKERS];
    logic [CNT_W-1:0]  tick_counter_next [NUM_SPEAKERS];
    logic [NUM_SPEAKERS-1:0] timer_running_reg, timer_running_next;
    logic [NUM_SPEAKERS-1:0] output_level_reg, output_level_next;

    logic              tx_valid_reg;
    logic [BYTE_W-1:0] tx_byte_reg;
    logic [1:0]        tone_levels_reg;

    logic [FREQ_W-1:0] freq;
    logic              in_range;
    logic              handshake;
    logic              load_result;
    logic              div_done;
    logic [QW-1:0]     quotient;
    logic [CNT_W-1:0]  new_compare;
    logic [1:0]        levels_next;

    assign freq        = {rx_byte, pending_freq_low_reg};
    assign in_range    = pending_speaker_reg < BYTE_W'(NUM_SPEAKERS);
    assign new_compare = CNT_W'(quotient) - CNT_W'(1);

    assign status.need_div = (kind == KIND_BYTE) && (phase_reg == PH_HI) && in_range
                             && (freq != '0);
    assign status.div_done = div_done;

    ucdtg_divider #(
        .DIVIDEND (TIMER_CLOCK_HZ)
    ) u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.take && status.need_div),
        .divisor  (freq),
        .done     (div_done),
        .quotient (quotient)
    );

    always_comb
    begin
        phase_next            = phase_reg;
        pending_speaker_next  = pending_speaker_reg;
        pending_freq_low_next = pending_freq_low_reg;
        compare_value_next    = compare_value_reg;
        tick_counter_next     = tick_counter_reg;
        timer_running_next    = timer_running_reg;
        output_level_next     = output_level_reg;
        handshake             = 1'b0;

        if (cmd.take)
        begin
            if (kind == KIND_TICK)
            begin
                for (int i = 0; i < NUM_SPEAKERS; i++)
                begin
                    if (timer_running_reg[i])
                    begin
                        if (tick_counter_reg[i] == compare_value_reg[i])
                        begin
                            tick_counter_next[i] = '0;
                            output_level_next[i] = !output_level_reg[i];
                        end
                        else
                        begin
                            tick_counter_next[i] = tick_counter_reg[i] + CNT_W'(1);
                        end
                    end
                end
            end
            else
            begin
                unique case (phase_reg)
                    PH_CMD:
                    begin
                        if (rx_byte == OPC_HELLO)
                        begin
                            handshake = 1'b1;
                        end
                        else if (rx_byte == OPC_TONE)
                        begin
                            phase_next = PH_SPK;
                        end
                    end
                    PH_SPK:
                    begin
                        pending_speaker_next = rx_byte;
                        phase_next           = PH_LO;
                    end
                    PH_LO:
                    begin
                        pending_freq_low_next = rx_byte;
                        phase_next            = PH_HI;
                    end
                    PH_HI:
                    begin
                        phase_next = PH_CMD;
                        // A zero frequency stops the speaker at once; others wait for the divider.
                        if (in_range && freq == '0)
                        begin
                            for (int i = 0; i < NUM_SPEAKERS; i++)
                            begin
                                if (pending_speaker_reg == BYTE_W'(i))
                                begin
                                    compare_value_next[i] = '0;
                                    timer_running_next[i] = 1'b0;
                                end
                            end
                        end
                    end
                    default:
                    begin
                        phase_next = PH_CMD;
                    end
                endcase
            end
        end

        if (cmd.commit)
        begin
            for (int i = 0; i < NUM_SPEAKERS; i++)
            begin
                if (pending_speaker_reg == BYTE_W'(i))
                begin
                    compare_value_next[i] = new_compare;
                    timer_running_next[i] = 1'b1;
                end
            end
        end
    end

    for (genvar j = 0; j < 2; j++)
    begin : g_levels
        if (j < NUM_SPEAKERS)
        begin : g_used
            assign levels_next[j] = output_level_next[j];
        end
        else
        begin : g_unused
            assign levels_next[j] = 1'b0;
        end
    end

    assign load_result = (cmd.take && !status.need_div) || cmd.commit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg            <= PH_CMD;
            pending_speaker_reg  <= '0;
            pending_freq_low_reg <= '0;
            for (int i = 0; i < NUM_SPEAKERS; i++)
            begin
                compare_value_reg[i] <= '0;
                tick_counter_reg[i]  <= '0;
            end
            timer_running_reg    <= '0;
            output_level_reg     <= '0;
            tx_valid_reg         <= 1'b0;
            tx_byte_reg          <= '0;
            tone_levels_reg      <= '0;
        end
        else
        begin
            phase_reg            <= phase_next;
            pending_speaker_reg  <= pending_speaker_next;
            pending_freq_low_reg <= pending_freq_low_next;
            compare_value_reg    <= compare_value_next;
            tick_counter_reg     <= tick_counter_next;
            timer_running_reg    <= timer_running_next;
            output_level_reg     <= output_level_next;
            if (load_result)
            begin
                tx_valid_reg    <= handshake;
                tx_byte_reg     <= handshake ? BYTE_W'(NUM_SPEAKERS) : '0;
                tone_levels_reg <= levels_next;
            end
        end
    end

    assign tx_valid    = tx_valid_reg;
    assign tx_byte     = tx_byte_reg;
    assign tone_levels = tone_levels_reg;

    // A quotient is only written back once the parser has closed the play command.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> phase_reg == PH_CMD)
        else $error("compare written while a command is still being parsed");

    // A reply byte always carries the speaker count.
    assert property (@(posedge clk) disable iff (!rst_n)
        tx_valid_reg |-> tx_byte_reg == BYTE_W'(NUM_SPEAKERS))
        else $error("reply byte differs from the speaker count");

    // Stopping speaker 0 also clears its compare.
    assert property (@(posedge clk) disable iff (!rst_n)
        $fell(timer_running_reg[0]) |-> compare_value_reg[0] == '0)
        else $error("stopped speaker kept a nonzero compare");

endmodule

// ===== design/ucdtg_ctrl.sv =====
// Controller: accepts items, waits on the divider and owns the result valid flag.
module ucdtg_ctrl import ucdtg_pkg::*; (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    output logic    out_valid,
    input  logic    out_ready,
    output cmd_t    cmd,
    input  status_t status
);

    typedef enum logic {
        S_IDLE,
        S_DIV
    } state_t;

    state_t state_reg;
    logic   out_valid_reg, out_valid_next;
    logic   take;

    assign in_ready   = (state_reg == S_IDLE) && (!out_valid_reg || out_ready);
    assign take       = in_valid && in_ready;
    assign cmd.take   = take;
    assign cmd.commit = (state_reg == S_DIV) && status.div_done;
    assign out_valid  = out_valid_reg;

    // A result leaves when it is accepted; a new one is loaded for a plain item or a commit.
    always_comb
    begin
        out_valid_next = out_valid_reg && !out_ready;
        if ((take && !status.need_div) || cmd.commit)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (take && status.need_div)
                    begin
                        state_reg <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    if (status.div_done)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // The divider only finishes while the controller is waiting for it.
    assert property (@(posedge clk) disable iff (!rst_n)
        status.div_done |-> state_reg == S_DIV)
        else $error("divider finished outside a divide");

    // No earlier result is left pending while a divide runs.
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DIV |-> !out_valid_reg)
        else $error("result pending during a divide");

    // A committed quotient always produces a result in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> out_valid_reg)
        else $error("committed play produced no result");

endmodule

// ===== design/uart_commanded_dual_tone_generator.sv =====
// Top level of the serial-commanded dual tone generator.
// Timing: a tick or a byte that needs no divide gives its result in the cycle after it is
// accepted; the last byte of a play with a nonzero frequency gives its result once the
// one-bit-per-cycle divider has finished. Ticks and plain bytes are taken at one item per cycle
// while results are accepted; no new item is taken until a running divide has finished.
// Reset: rst_n clears the parser, all timers, counters and speaker levels asynchronously.
module uart_commanded_dual_tone_generator import ucdtg_pkg::*; #(
    parameter int NUM_SPEAKERS   = 2,
    parameter int TIMER_CLOCK_HZ = 500000
) (
    input  logic       clk,
    input  logic       rst_n,
    ucdtg_req_if.sink   request,
    ucdtg_rsp_if.source response
);

    // The controller and datapath talk only through these two groups.
    cmd_t    cmd;
    status_t status;

    // The controller decides when an item is accepted and when its result is shown.
    // An item is taken whenever no divide runs and the result register is free or
    // being emptied in the same cycle.
    ucdtg_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (request.valid),
        .in_ready  (request.ready),
        .out_valid (response.valid),
        .out_ready (response.ready),
        .cmd       (cmd),
        .status    (status)
    );

    // The datapath holds the parser, the per-speaker timers, the divider for the
    // compare value and the registered result item.
    ucdtg_datapath #(
        .NUM_SPEAKERS   (NUM_SPEAKERS),
        .TIMER_CLOCK_HZ (TIMER_CLOCK_HZ)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .kind        (request.kind),
        .rx_byte     (request.rx_byte),
        .tx_valid    (response.tx_valid),
        .tx_byte     (response.tx_byte),
        .tone_levels (response.tone_levels)
    );

endmodule
